### rtl/asmmc_pkg.sv
// Package for the averaged sensor min/max calibrator.
// Shared widths, constants, command codes, state type and control structs.
// No dependencies.
package asmmc_pkg;

  // Field widths
  localparam int unsigned SMP_W  = 12;
  localparam int unsigned ACC_W  = 16;
  localparam int unsigned PCT_W  = 10;
  localparam int unsigned PROD_W = 22;

  // Percent divider: 23-bit dividend, 13-bit divisor, one quotient bit per cycle
  localparam int unsigned DIV_DW = 23;
  localparam int unsigned DIV_VW = 13;
  localparam int unsigned DIV_CW = 5;

  localparam logic [SMP_W-1:0] FULL_SCALE    = 12'd4095;
  localparam logic [PCT_W-1:0] PERCENT_SCALE = 10'd1000;

  // Input word command codes
  typedef enum logic [1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_START  = 2'd1,
    MODE_STOP   = 2'd2,
    MODE_RESET  = 2'd3
  } mode_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG,
    ST_SCALE,
    ST_PCT_START,
    ST_PCT_WAIT,
    ST_EMIT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic take_sample;
    logic apply_mode;
    logic div_start;
    logic latch_avg;
    logic load_scale;
    logic latch_pct;
    logic load_out;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last_sample;
    logic div_done;
    logic pct_special;
    logic out_free;
  } dp_status_t;

endpackage

### rtl/asmmc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on asmmc_pkg for operand widths.
module asmmc_div import asmmc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_DW-1:0] dividend_i,
  input  logic [DIV_VW-1:0] divisor_i,
  output logic              done_o,
  output logic [DIV_DW-1:0] quotient_o
);

  logic [DIV_VW-1:0] rem_q, rem_d;
  logic [DIV_DW-1:0] quo_q, quo_d;
  logic [DIV_VW-1:0] dvs_q;
  logic [DIV_CW-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DIV_VW:0]   trial;
  logic [DIV_VW:0]   diff;

  // One restoring step: shift in next dividend bit, try subtract
  always_comb begin
    trial  = {rem_q, quo_q[DIV_DW-1]};
    diff   = trial - {1'b0, dvs_q};
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = DIV_CW'(DIV_DW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[DIV_VW]) begin
        rem_d = diff[DIV_VW-1:0];
        quo_d = {quo_q[DIV_DW-2:0], 1'b1};
      end else begin
        rem_d = trial[DIV_VW-1:0];
        quo_d = {quo_q[DIV_DW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operands and partial results
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### rtl/asmmc_ctrl.sv
// Controller state machine: accepts words, sequences averaging, scaling, output.
// Depends on asmmc_pkg for state, command and status types.
module asmmc_ctrl import asmmc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] mode_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   accept;
  logic   is_sample;

  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign is_sample = (mode_e'(mode_i) == MODE_SAMPLE);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && is_sample && status_i.last_sample) begin
          state_d = ST_AVG;
        end
      end
      ST_AVG:   state_d = ST_SCALE;
      ST_SCALE: state_d = ST_PCT_START;
      ST_PCT_START: begin
        state_d = status_i.pct_special ? ST_EMIT : ST_PCT_WAIT;
      end
      ST_PCT_WAIT: begin
        if (status_i.div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.take_sample = accept && is_sample;
        cmd_o.apply_mode  = accept && !is_sample;
      end
      ST_AVG:       cmd_o.latch_avg = 1'b1;
      ST_SCALE:     cmd_o.load_scale = 1'b1;
      ST_PCT_START: begin
        cmd_o.div_start = !status_i.pct_special;
        cmd_o.latch_pct = status_i.pct_special;
      end
      ST_PCT_WAIT:  cmd_o.latch_pct = status_i.div_done;
      ST_EMIT:      cmd_o.load_out = status_i.out_free;
      default:      cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

### rtl/asmmc_dp.sv
// Datapath: accumulator, calibration marks, mean and scaling multipliers, output.
// Depends on asmmc_pkg and instantiates asmmc_div.
module asmmc_dp import asmmc_pkg::*; #(
  parameter int unsigned SAMPLES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       mode_i,
  input  logic [SMP_W-1:0] sample_i,
  input  ctrl_cmd_t        cmd_i,
  output dp_status_t       status_o,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output logic [SMP_W-1:0] average_o,
  output logic [PCT_W-1:0] percent_tenths_o,
  output logic [SMP_W-1:0] low_mark_o,
  output logic [SMP_W-1:0] high_mark_o,
  output logic             calibrating_flag_o
);

  localparam int unsigned CNT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;

  // Reciprocal of the block length, exact for any sum below 2^ACC_W
  localparam int unsigned AVG_SH = ACC_W + $clog2(SAMPLES);
  localparam int unsigned RCP_W  = ACC_W + 1;
  localparam int unsigned MUL_W  = ACC_W + RCP_W;
  localparam logic [RCP_W-1:0] AVG_RCP =
    RCP_W'(((64'd1 << AVG_SH) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));

  logic [ACC_W-1:0]  acc_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [SMP_W-1:0]  low_q, high_q;
  logic              track_q;
  logic [SMP_W-1:0]  avg_q;
  logic [PROD_W-1:0] prod_q;
  logic [SMP_W-1:0]  span_q;
  logic              special_q;
  logic [PCT_W-1:0]  fix_q;
  logic [PCT_W-1:0]  pct_q;
  logic              out_valid_q;

  logic [DIV_DW-1:0] div_dividend;
  logic [DIV_VW-1:0] div_divisor;
  logic              div_done;
  logic [DIV_DW-1:0] div_quot;
  logic [MUL_W-1:0]  avg_prod;
  logic [MUL_W-1:0]  avg_shift;
  logic [SMP_W-1:0]  avg_new;
  logic              range_empty, below, above;
  logic [SMP_W-1:0]  diff;
  logic [PROD_W-1:0] prod;

  // Percent divider: rounded (2*num + span) / (2*span)
  assign div_dividend = {prod_q, 1'b0} + DIV_DW'(span_q);
  assign div_divisor  = {span_q, 1'b0};

  asmmc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Block mean by reciprocal multiply
  assign avg_prod  = MUL_W'(acc_q) * MUL_W'(AVG_RCP);
  assign avg_shift = avg_prod >> AVG_SH;
  assign avg_new   = avg_shift[SMP_W-1:0];

  // Accumulator, count and calibration state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      cnt_q   <= '0;
      low_q   <= FULL_SCALE;
      high_q  <= '0;
      track_q <= 1'b0;
    end else begin
      if (cmd_i.take_sample) begin
        acc_q <= acc_q + ACC_W'(sample_i);
        cnt_q <= status_o.last_sample ? '0 : cnt_q + 1'b1;
      end
      if (cmd_i.apply_mode) begin
        unique case (mode_e'(mode_i))
          MODE_START: begin
            track_q <= 1'b1;
            low_q   <= FULL_SCALE;
            high_q  <= '0;
          end
          MODE_RESET: begin
            track_q <= 1'b0;
            low_q   <= FULL_SCALE;
            high_q  <= '0;
          end
          MODE_STOP:   track_q <= 1'b0;
          MODE_SAMPLE: track_q <= track_q;
          default:     track_q <= track_q;
        endcase
      end
      if (cmd_i.latch_avg) begin
        acc_q <= '0;
        if (track_q && (avg_new < low_q)) begin
          low_q <= avg_new;
        end
        if (track_q && (avg_new > high_q)) begin
          high_q <= avg_new;
        end
      end
    end
  end

  // Range checks and scaled offset
  assign range_empty = (high_q <= low_q);
  assign below       = (avg_q <= low_q);
  assign above       = (avg_q >= high_q);
  assign diff        = avg_q - low_q;
  assign prod        = PROD_W'(diff) * PROD_W'(PERCENT_SCALE);

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_avg) begin
      avg_q <= avg_new;
    end
    if (cmd_i.load_scale) begin
      prod_q    <= prod;
      span_q    <= high_q - low_q;
      special_q <= range_empty || below || above;
      fix_q     <= (!range_empty && !below && above) ? PERCENT_SCALE : '0;
    end
    if (cmd_i.latch_pct) begin
      pct_q <= special_q ? fix_q : div_quot[PCT_W-1:0];
    end
  end

  // Output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      average_o          <= avg_q;
      percent_tenths_o   <= pct_q;
      low_mark_o         <= low_q;
      high_mark_o        <= high_q;
      calibrating_flag_o <= track_q;
    end
  end

  assign out_valid_o = out_valid_q;

  assign status_o.last_sample = (cnt_q == CNT_W'(SAMPLES - 1));
  assign status_o.div_done    = div_done;
  assign status_o.pct_special = special_q;
  assign status_o.out_free    = !out_valid_q || !out_stall_i;

endmodule

### rtl/averaged_sensor_min_max_calibrator.sv
// Channel  Valid        Stall        Payload
// input    in_valid_i   in_stall_o   mode_i, sample_i
// output   out_valid_o  out_stall_i  average_o, percent_tenths_o, low_mark_o,
//                                    high_mark_o, calibrating_flag_o
//
// Commands and samples that do not close a block never stall the input.
// A closing sample stalls input until its word is loaded: mean by reciprocal
// multiply, scale, then 23 divider steps to round the percent unless clamped.
// Reset clears the sum, count and tracking flag; low mark 4095, high mark 0.
// A word waiting in the output register does not block input; a finished
// block waits only if the previous word has not yet been taken.
// Top level; depends on asmmc_pkg, asmmc_ctrl, asmmc_dp.
module averaged_sensor_min_max_calibrator import asmmc_pkg::*; #(
  parameter int unsigned SAMPLES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       mode_i,
  input  logic [SMP_W-1:0] sample_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [SMP_W-1:0] average_o,
  output logic [PCT_W-1:0] percent_tenths_o,
  output logic [SMP_W-1:0] low_mark_o,
  output logic [SMP_W-1:0] high_mark_o,
  output logic             calibrating_flag_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  asmmc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  asmmc_dp #(
    .SAMPLES (SAMPLES)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .mode_i             (mode_i),
    .sample_i           (sample_i),
    .cmd_i              (cmd),
    .status_o           (status),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .average_o          (average_o),
    .percent_tenths_o   (percent_tenths_o),
    .low_mark_o         (low_mark_o),
    .high_mark_o        (high_mark_o),
    .calibrating_flag_o (calibrating_flag_o)
  );

endmodule
